// ----- rtl/cvm_pkg.sv -----
`timescale 1ns / 1ps

package cvm_pkg;

   localparam int CODE_W    = 16;
   localparam int IDX_W     = 4;
   localparam int AVG_W     = 24;
   localparam int SUM_W     = 30;
   localparam int FAULT_W   = 2;
   localparam int CSR_IDX_W = 1;
   localparam int REQ_W     = 32;
   localparam int RSP_W     = 96;

   localparam logic [FAULT_W-1:0] FAULT_NONE  = 2'd0;
   localparam logic [FAULT_W-1:0] FAULT_OVER  = 2'd1;
   localparam logic [FAULT_W-1:0] FAULT_UNDER = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_OVER_LIMIT  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UNDER_LIMIT = 1'd1;

   localparam logic [CODE_W-1:0] OVER_LIMIT_RESET  = 16'd42000;
   localparam logic [CODE_W-1:0] UNDER_LIMIT_RESET = 16'd28000;

   localparam logic [7:0] AVG_KEEP_COEF = 8'd205;
   localparam logic [7:0] AVG_NEW_COEF  = 8'd51;
   localparam logic [7:0] AVG_ROUND     = 8'd128;

   typedef struct packed {
      logic [6:0]        pad;
      logic [CODE_W-1:0] raw_code;
      logic [IDX_W-1:0]  cell_index;
      logic [IDX_W-1:0]  ic_index;
      logic              bank_select;
   } cvm_req_type;

   typedef struct packed {
      logic [IDX_W-1:0]  max_cell;
      logic [IDX_W-1:0]  max_ic;
      logic [CODE_W-1:0] max_value;
      logic [IDX_W-1:0]  min_cell;
      logic [IDX_W-1:0]  min_ic;
      logic [CODE_W-1:0] min_value;
   } cvm_extremes_type;

   typedef struct packed {
      logic              check;
      logic              bank;
      logic [CODE_W-1:0] value;
      logic [IDX_W-1:0]  ic;
      logic [IDX_W-1:0]  cell_no;
   } cvm_ext_upd_type;

   typedef struct packed {
      logic [SUM_W-1:0]   module_sum;
      cvm_extremes_type   extremes;
      logic [CODE_W-1:0]  cell_average;
      logic [FAULT_W-1:0] fault_code;
   } cvm_rsp_type;

endpackage

// ----- rtl/cvm_ram.sv -----
`timescale 1ns / 1ps

module cvm_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 216
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/cvm_extremes.sv -----
`timescale 1ns / 1ps

module cvm_extremes
   import cvm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  cvm_ext_upd_type  upd,
   output cvm_extremes_type report
);

   cvm_extremes_type ext_ff [2];
   cvm_extremes_type cur;
   cvm_extremes_type ext_in;

   always_comb begin
      cur    = ext_ff[upd.bank];
      ext_in = cur;
      if (upd.check) begin
         if (upd.value < cur.min_value) begin
            ext_in.min_value = upd.value;
            ext_in.min_ic    = upd.ic;
            ext_in.min_cell  = upd.cell_no;
         end
         if (upd.value > cur.max_value) begin
            ext_in.max_value = upd.value;
            ext_in.max_ic    = upd.ic;
            ext_in.max_cell  = upd.cell_no;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < 2; b++) begin
            ext_ff[b].min_value <= '1;
            ext_ff[b].min_ic    <= '0;
            ext_ff[b].min_cell  <= '0;
            ext_ff[b].max_value <= '0;
            ext_ff[b].max_ic    <= '0;
            ext_ff[b].max_cell  <= '0;
         end
      end else if (enable) begin
         ext_ff[upd.bank] <= ext_in;
      end
   end

   // report the state after this item's update
   assign report = ext_in;

endmodule

// ----- rtl/cell_voltage_monitor_top.sv -----
`timescale 1ns / 1ps

// Cell voltage monitor.
// req channel: one cell sample per transfer (bank, IC, cell, raw code); tuser
// set seeds the cell average with the code and skips the limit checks.
// rsp channel: one result per sample: fault code, updated cell average, the
// bank's minimum and maximum with their location, and the module sum.
// csr port: write-only; index 0 is the over-voltage limit, 1 the under-voltage
// limit. Write only while no sample is in flight.
// Path: input register, average store read, result register. Throughput: one
// sample per cycle while rsp_tready is high; the averages sit in a
// single-port-write, registered-read store, with the last write forwarded to
// the next read.
// Reset: all averages read as zero, module sums zero, limits to defaults,
// bank minimum to full scale and maximum to zero.
// When rsp_tready is low the result is held; upstream stages keep filling
// until every stage is occupied, then req_tready drops.

module cell_voltage_monitor_top
   import cvm_pkg::*;
#(
   parameter int NUM_IC         = 9,
   parameter int CELLS_PER_IC   = 12,
   parameter int ICS_PER_MODULE = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // bank_select, ic_index, cell_index, raw_code, zero pad
   input  logic [REQ_W-1:0]     req_tdata,
   // seed_average
   input  logic                 req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // fault_code, cell_average, bank_min_value, bank_min_ic, bank_min_cell,
   // bank_max_value, bank_max_ic, bank_max_cell, module_sum
   output logic [RSP_W-1:0]     rsp_tdata,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CODE_W-1:0]    csr_wdata
);

   localparam int CELLS_PER_BANK   = NUM_IC * CELLS_PER_IC;
   localparam int DEPTH            = 2 * CELLS_PER_BANK;
   localparam int ADDR_W           = $clog2(DEPTH);
   localparam int MODULES_PER_BANK = (NUM_IC + ICS_PER_MODULE - 1) / ICS_PER_MODULE;
   localparam int NUM_MOD          = 2 * MODULES_PER_BANK;
   localparam int MOD_W            = $clog2(NUM_MOD);

   cvm_req_type req;
   logic        req_fire;
   logic        in_range;
   logic [IDX_W-1:0]  mod_in_bank;
   logic [ADDR_W-1:0] addr_calc;
   logic [MOD_W-1:0]  midx_calc;

   logic              s1_valid_ff, s1_valid_in;
   logic              s1_inrange_ff, s1_seed_ff, s1_bank_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [MOD_W-1:0]  s1_midx_ff;
   logic [IDX_W-1:0]  s1_ic_ff, s1_cell_ff;
   logic [CODE_W-1:0] s1_code_ff;

   logic              s2_valid_ff;
   logic              s2_inrange_ff, s2_seed_ff, s2_bank_ff;
   logic [ADDR_W-1:0] s2_addr_ff;
   logic [MOD_W-1:0]  s2_midx_ff;
   logic [IDX_W-1:0]  s2_ic_ff, s2_cell_ff;
   logic [CODE_W-1:0] s2_code_ff;

   logic              out_free, s2_move, s2_fire, ram_we;
   logic [AVG_W-1:0]  ram_rdata;
   logic [DEPTH-1:0]  valid_ff;
   logic              fwd_valid_ff;
   logic [ADDR_W-1:0] fwd_addr_ff;
   logic [AVG_W-1:0]  fwd_data_ff;

   logic [AVG_W-1:0]  old_avg, new_avg;
   logic [31:0]       keep_prod, new_prod, acc;
   logic [CODE_W-1:0] avg_int;
   logic [FAULT_W-1:0] fault;
   logic [SUM_W-1:0]  sum_ff [NUM_MOD];
   logic [SUM_W-1:0]  sum_new;

   logic [CODE_W-1:0] over_limit_ff, under_limit_ff;

   cvm_ext_upd_type   ext_upd;
   cvm_extremes_type  ext_report;
   cvm_rsp_type       rsp_data_ff, rsp_data_in;
   logic              rsp_valid_ff;

   assign req = cvm_req_type'(req_tdata);

   always_ff @(posedge clock) begin
      if (reset) begin
         over_limit_ff  <= OVER_LIMIT_RESET;
         under_limit_ff <= UNDER_LIMIT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_OVER_LIMIT:  over_limit_ff  <= csr_wdata;
            CSR_UNDER_LIMIT: under_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // handshake
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s2_move    = !s2_valid_ff || out_free;
   assign s2_fire    = s2_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || s2_move;
   assign req_fire   = req_tvalid && req_tready;

   // address and module of the incoming sample
   always_comb begin
      in_range    = (int'(req.ic_index) < NUM_IC) && (int'(req.cell_index) < CELLS_PER_IC);
      mod_in_bank = '0;
      for (int k = 1; k < 16; k++) begin
         if (int'(req.ic_index) >= k * ICS_PER_MODULE) begin
            mod_in_bank = mod_in_bank + 4'd1;
         end
      end
      addr_calc = '0;
      midx_calc = '0;
      if (in_range) begin
         addr_calc = ADDR_W'(int'(req.bank_select) * CELLS_PER_BANK
                           + int'(req.ic_index) * CELLS_PER_IC + int'(req.cell_index));
         midx_calc = MOD_W'(int'(req.bank_select) * MODULES_PER_BANK + int'(mod_in_bank));
      end
   end

   assign s1_valid_in = req_fire ? 1'b1 : (s2_move ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (s2_move) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_inrange_ff <= in_range;
         s1_seed_ff    <= req_tuser;
         s1_bank_ff    <= req.bank_select;
         s1_addr_ff    <= addr_calc;
         s1_midx_ff    <= midx_calc;
         s1_ic_ff      <= req.ic_index;
         s1_cell_ff    <= req.cell_index;
         s1_code_ff    <= req.raw_code;
      end
      if (s2_move) begin
         s2_inrange_ff <= s1_inrange_ff;
         s2_seed_ff    <= s1_seed_ff;
         s2_bank_ff    <= s1_bank_ff;
         s2_addr_ff    <= s1_addr_ff;
         s2_midx_ff    <= s1_midx_ff;
         s2_ic_ff      <= s1_ic_ff;
         s2_cell_ff    <= s1_cell_ff;
         s2_code_ff    <= s1_code_ff;
      end
   end

   assign ram_we = s2_fire && s2_inrange_ff;

   cvm_ram #(
      .WIDTH (AVG_W),
      .DEPTH (DEPTH)
   ) u_avg_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s2_addr_ff),
      .wr_data (new_avg),
      .rd_en   (s2_move),
      .rd_addr (s1_addr_ff),
      .rd_data (ram_rdata)
   );

   // forward the last write; unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         fwd_valid_ff <= 1'b0;
      end else if (ram_we) begin
         valid_ff[s2_addr_ff] <= 1'b1;
         fwd_valid_ff         <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_we) begin
         fwd_addr_ff <= s2_addr_ff;
         fwd_data_ff <= new_avg;
      end
   end

   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == s2_addr_ff)) begin
         old_avg = fwd_data_ff;
      end else if (valid_ff[s2_addr_ff]) begin
         old_avg = ram_rdata;
      end else begin
         old_avg = '0;
      end
      keep_prod = 32'(old_avg) * 32'(AVG_KEEP_COEF);
      new_prod  = 32'({s2_code_ff, 8'd0}) * 32'(AVG_NEW_COEF);
      acc       = keep_prod + new_prod + 32'(AVG_ROUND);
      if (s2_seed_ff) begin
         new_avg = {s2_code_ff, 8'd0};
      end else begin
         new_avg = acc[31:8];
      end
      avg_int = new_avg[AVG_W-1:8];
      fault   = FAULT_NONE;
      if (!s2_seed_ff) begin
         if (avg_int >= over_limit_ff) begin
            fault = FAULT_OVER;
         end else if (avg_int <= under_limit_ff) begin
            fault = FAULT_UNDER;
         end
      end
      sum_new = sum_ff[s2_midx_ff] + SUM_W'(new_avg) - SUM_W'(old_avg);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int m = 0; m < NUM_MOD; m++) begin
            sum_ff[m] <= '0;
         end
      end else if (ram_we) begin
         sum_ff[s2_midx_ff] <= sum_new;
      end
   end

   always_comb begin
      ext_upd.check   = s2_inrange_ff && !s2_seed_ff;
      ext_upd.bank    = s2_bank_ff;
      ext_upd.value   = avg_int;
      ext_upd.ic      = s2_ic_ff;
      ext_upd.cell_no = s2_cell_ff;
   end

   cvm_extremes u_extremes (
      .clock  (clock),
      .reset  (reset),
      .enable (s2_fire),
      .upd    (ext_upd),
      .report (ext_report)
   );

   always_comb begin
      rsp_data_in.extremes = ext_report;
      if (s2_inrange_ff) begin
         rsp_data_in.fault_code   = fault;
         rsp_data_in.cell_average = avg_int;
         rsp_data_in.module_sum   = sum_new;
      end else begin
         rsp_data_in.fault_code   = FAULT_NONE;
         rsp_data_in.cell_average = '0;
         rsp_data_in.module_sum   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_seed_no_fault: assert property (@(posedge clock) disable iff (reset)
      (s2_fire && s2_seed_ff) |=> (rsp_data_ff.fault_code == FAULT_NONE))
      else $error("seed sample reported a fault");

   a_skip_zero: assert property (@(posedge clock) disable iff (reset)
      (s2_fire && !s2_inrange_ff) |=>
         (rsp_data_ff.cell_average == '0 && rsp_data_ff.module_sum == '0))
      else $error("out-of-range sample reported non-zero average or sum");

   a_write_in_store: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (int'(s2_addr_ff) < DEPTH))
      else $error("average store written beyond its depth");

   a_result_follows_s2: assert property (@(posedge clock) disable iff (reset)
      s2_fire |=> rsp_valid_ff)
      else $error("result lost after compute stage");

endmodule
